>>> design/rrfe_pkg.sv
// shared types and constants for the rounded rectangle fill engine
`timescale 1ns / 1ps
`default_nettype none

package rrfe_pkg;

    localparam int COORD_W = 11;
    localparam int RAD_W   = 10;
    localparam int COL_W   = 8;
    localparam int PIX_W   = 3 * COL_W;
    localparam int MUL_W   = 11;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQ_W    = 2 * RAD_W;

    typedef enum logic [1:0] {
        KIND_DRAW  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_SETUP,
        ST_RAD,
        ST_RSQ,
        ST_RCAP,
        ST_ROW,
        ST_DYCAP,
        ST_PMUL,
        ST_PWR,
        ST_FILL,
        ST_RDMUL,
        ST_RDADDR,
        ST_RDDATA,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_op_t;

endpackage

`default_nettype wire

>>> design/rrfe_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rrfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/rrfe_mul.sv
// shared registered multiplier for squares and row addresses
`timescale 1ns / 1ps
`default_nettype none

module rrfe_mul
    import rrfe_pkg::*;
(
    input  wire logic              clk,
    input  wire mul_op_t           op,
    output logic      [PROD_W-1:0] prod
);

    always_ff @(posedge clk)
    begin
        prod <= op.a * op.b;
    end

endmodule

`default_nettype wire

>>> design/rounded_rect_fill_engine_core.sv
// top level of the rounded rectangle fill engine with sequencer and frame store
//
// usage:
//   input channel in_valid/in_stall carries one transaction of kind, x0, y0, x1, y1,
//   radius and colour; it is taken only while the sequencer is idle.
//   output channel out_valid/out_stall returns exactly one transaction per input:
//   the read pixel and in_canvas (zeros for draw and clear) and done_kind.
//   one registered multiplier is reused for r*r, the row base address,
//   dy*dy once per row and dx*dx once per pixel; the frame store takes one write a cycle.
//   after reset the whole store is wiped to black,
//   during which in_stall stays high.
//   a finished result sits in the output register; while out_stall holds it,
//   the next transaction is still taken and runs until its own result is due.
`timescale 1ns / 1ps
`default_nettype none

module rounded_rect_fill_engine_core
    import rrfe_pkg::*;
#(
    parameter int CANVAS_W = 128,
    parameter int CANVAS_H = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                kind,
    input  wire logic signed [COORD_W-1:0] x0,
    input  wire logic signed [COORD_W-1:0] y0,
    input  wire logic signed [COORD_W-1:0] x1,
    input  wire logic signed [COORD_W-1:0] y1,
    input  wire logic [RAD_W-1:0]          radius,
    input  wire logic [COL_W-1:0]          red,
    input  wire logic [COL_W-1:0]          green,
    input  wire logic [COL_W-1:0]          blue,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [COL_W-1:0]               pixel_red,
    output logic [COL_W-1:0]               pixel_green,
    output logic [COL_W-1:0]               pixel_blue,
    output logic                           in_canvas,
    output logic [1:0]                     done_kind
);

    localparam int DEPTH = CANVAS_W * CANVAS_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(CANVAS_W);
    localparam int YW    = $clog2(CANVAS_H);
    localparam logic signed [COORD_W:0] XMAX = (COORD_W+1)'(CANVAS_W - 1);
    localparam logic signed [COORD_W:0] YMAX = (COORD_W+1)'(CANVAS_H - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(CANVAS_W);
    localparam logic [MUL_W-1:0] W_OP   = MUL_W'(CANVAS_W);

    state_t state_reg, state_next;

    logic [1:0]                kind_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [PIX_W-1:0]          col_reg;

    logic [XW-1:0]    lox_reg, hix_reg, lxr_reg, hxr_reg, x_reg;
    logic [YW-1:0]    loy_reg, hiy_reg, tyr_reg, byr_reg, y_reg;
    logic [RAD_W-1:0] r_reg;
    logic [SQ_W-1:0]  rsq_reg, dysq_reg;
    logic             cr_reg, cc_reg;
    logic [AW-1:0]    addr_reg, base_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             incan_reg;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_incan_reg;
    logic [1:0]       out_kind_reg;

    mul_op_t          mul_op;
    logic [PROD_W-1:0] prod;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [PIX_W-1:0] ram_wdata, ram_rdata;
    logic             resp_load;

    // clipping of the two corners
    logic signed [COORD_W:0] ax_e, ay_e, bx_e, by_e;
    logic signed [COORD_W:0] mnx, mxx, mny, mxy;
    logic                    box_empty, rd_inside;
    logic [XW-1:0]           lox_c, hix_c;
    logic [YW-1:0]           loy_c, hiy_c;

    assign ax_e = $signed({ax_reg[COORD_W-1], ax_reg});
    assign ay_e = $signed({ay_reg[COORD_W-1], ay_reg});
    assign bx_e = $signed({bx_reg[COORD_W-1], bx_reg});
    assign by_e = $signed({by_reg[COORD_W-1], by_reg});

    assign mnx = (ax_e < bx_e) ? ax_e : bx_e;
    assign mxx = (ax_e < bx_e) ? bx_e : ax_e;
    assign mny = (ay_e < by_e) ? ay_e : by_e;
    assign mxy = (ay_e < by_e) ? by_e : ay_e;

    assign box_empty = (mnx > XMAX) || (mxx < 0) || (mny > YMAX) || (mxy < 0);
    assign rd_inside = (ax_e >= 0) && (ax_e <= XMAX) && (ay_e >= 0) && (ay_e <= YMAX);

    assign lox_c = (mnx < 0) ? '0 : mnx[XW-1:0];
    assign hix_c = (mxx > XMAX) ? XMAX[XW-1:0] : mxx[XW-1:0];
    assign loy_c = (mny < 0) ? '0 : mny[YW-1:0];
    assign hiy_c = (mxy > YMAX) ? YMAX[YW-1:0] : mxy[YW-1:0];

    // radius limit, truncating halves of the clipped extent
    logic [XW-1:0]    wx;
    logic [YW-1:0]    hy;
    logic [RAD_W-1:0] halfx, halfy, rmin_a, rmin;

    assign wx     = hix_reg - lox_reg;
    assign hy     = hiy_reg - loy_reg;
    assign halfx  = RAD_W'(wx >> 1);
    assign halfy  = RAD_W'(hy >> 1);
    assign rmin_a = (halfx < halfy) ? halfx : halfy;
    assign rmin   = (rad_reg < rmin_a) ? rad_reg : rmin_a;

    // corner distances
    logic             top_c, bot_c, left_c, right_c;
    logic [RAD_W-1:0] dym, dxm;
    logic [SQ_W:0]    sq_sum;
    logic             keep;
    logic             last_x, last_y;

    assign top_c   = y_reg < tyr_reg;
    assign bot_c   = y_reg > byr_reg;
    assign left_c  = x_reg < lxr_reg;
    assign right_c = x_reg > hxr_reg;
    assign dym = top_c ? RAD_W'(tyr_reg - y_reg) : (bot_c ? RAD_W'(y_reg - byr_reg) : '0);
    assign dxm = left_c ? RAD_W'(lxr_reg - x_reg) : (right_c ? RAD_W'(x_reg - hxr_reg) : '0);

    assign sq_sum = {1'b0, prod[SQ_W-1:0]} + {1'b0, dysq_reg};
    assign keep   = !(cr_reg && cc_reg) || (sq_sum <= {1'b0, rsq_reg});
    assign last_x = x_reg == hix_reg;
    assign last_y = y_reg == hiy_reg;

    rrfe_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    rrfe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WIPE:
            begin
                if (addr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                case (kind_reg)
                    KIND_DRAW:  state_next = box_empty ? ST_RESP : ST_RAD;
                    KIND_READ:  state_next = rd_inside ? ST_RDMUL : ST_RESP;
                    KIND_CLEAR: state_next = ST_FILL;
                    default:    state_next = ST_RESP;
                endcase
            end
            ST_RAD:    state_next = ST_RSQ;
            ST_RSQ:    state_next = ST_RCAP;
            ST_RCAP:   state_next = ST_ROW;
            ST_ROW:    state_next = ST_DYCAP;
            ST_DYCAP:  state_next = ST_PWR;
            ST_PMUL:   state_next = ST_PWR;
            ST_PWR:
            begin
                if (!last_x)
                begin
                    state_next = ST_PMUL;
                end
                else if (!last_y)
                begin
                    state_next = ST_ROW;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FILL:
            begin
                if (addr_reg == ADDR_LAST)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RDMUL:  state_next = ST_RDADDR;
            ST_RDADDR: state_next = ST_RDDATA;
            ST_RDDATA: state_next = ST_RESP;
            ST_RESP:
            begin
                if (resp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        mul_op.a  = '0;
        mul_op.b  = '0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = col_reg;
        ram_raddr = addr_reg;
        resp_load = 1'b0;
        case (state_reg)
            ST_WIPE:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RAD:
            begin
                mul_op.a = MUL_W'(loy_reg);
                mul_op.b = W_OP;
            end
            ST_RSQ:
            begin
                mul_op.a = MUL_W'(r_reg);
                mul_op.b = MUL_W'(r_reg);
            end
            ST_ROW:
            begin
                mul_op.a = MUL_W'(dym);
                mul_op.b = MUL_W'(dym);
            end
            ST_DYCAP, ST_PMUL:
            begin
                mul_op.a = MUL_W'(dxm);
                mul_op.b = MUL_W'(dxm);
            end
            ST_PWR:
            begin
                ram_we = keep;
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
            end
            ST_RDMUL:
            begin
                mul_op.a = MUL_W'(ay_reg[YW-1:0]);
                mul_op.b = W_OP;
            end
            ST_RDADDR:
            begin
                ram_raddr = prod[AW-1:0] + AW'(ax_reg[XW-1:0]);
            end
            ST_RESP:
            begin
                resp_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_WIPE, ST_FILL:
                begin
                    addr_reg <= addr_reg + AW'(1);
                end
                ST_SETUP:
                begin
                    addr_reg <= '0;
                end
                ST_RCAP:
                begin
                    addr_reg <= base_reg + AW'(lox_reg);
                end
                ST_PWR:
                begin
                    if (!last_x)
                    begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                    else
                    begin
                        addr_reg <= base_reg + ROW_STEP + AW'(lox_reg);
                    end
                end
                default:
                begin
                    addr_reg <= addr_reg;
                end
            endcase
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                kind_reg <= kind;
                ax_reg   <= x0;
                ay_reg   <= y0;
                bx_reg   <= x1;
                by_reg   <= y1;
                rad_reg  <= radius;
                col_reg  <= {red, green, blue};
            end
            ST_SETUP:
            begin
                lox_reg   <= lox_c;
                hix_reg   <= hix_c;
                loy_reg   <= loy_c;
                hiy_reg   <= hiy_c;
                pix_reg   <= '0;
                incan_reg <= 1'b0;
            end
            ST_RAD:
            begin
                r_reg <= rmin;
            end
            ST_RSQ:
            begin
                base_reg <= prod[AW-1:0];
                lxr_reg  <= lox_reg + XW'(r_reg);
                hxr_reg  <= hix_reg - XW'(r_reg);
                tyr_reg  <= loy_reg + YW'(r_reg);
                byr_reg  <= hiy_reg - YW'(r_reg);
            end
            ST_RCAP:
            begin
                rsq_reg <= prod[SQ_W-1:0];
                x_reg   <= lox_reg;
                y_reg   <= loy_reg;
            end
            ST_ROW:
            begin
                cr_reg <= top_c || bot_c;
            end
            ST_DYCAP:
            begin
                dysq_reg <= prod[SQ_W-1:0];
                cc_reg   <= left_c || right_c;
            end
            ST_PMUL:
            begin
                cc_reg <= left_c || right_c;
            end
            ST_PWR:
            begin
                if (!last_x)
                begin
                    x_reg <= x_reg + XW'(1);
                end
                else
                begin
                    x_reg    <= lox_reg;
                    y_reg    <= y_reg + YW'(1);
                    base_reg <= base_reg + ROW_STEP;
                end
            end
            ST_RDDATA:
            begin
                pix_reg   <= ram_rdata;
                incan_reg <= 1'b1;
            end
            default:
            begin
                kind_reg <= kind_reg;
            end
        endcase
        if (resp_load)
        begin
            out_pix_reg   <= pix_reg;
            out_incan_reg <= incan_reg;
            out_kind_reg  <= kind_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_red   = out_pix_reg[PIX_W-1 -: COL_W];
    assign pixel_green = out_pix_reg[2*COL_W-1 -: COL_W];
    assign pixel_blue  = out_pix_reg[COL_W-1:0];
    assign in_canvas   = out_incan_reg;
    assign done_kind   = out_kind_reg;

    // an accepted transaction always enters setup next
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SETUP))
        else $error("accepted transaction did not enter setup");

    // a result only appears from the response state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESP))
        else $error("result raised outside response state");

    // pixel writes stay inside the clipped box
    a_pixel_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PWR) |-> ((x_reg >= lox_reg) && (x_reg <= hix_reg)
                                   && (y_reg >= loy_reg) && (y_reg <= hiy_reg)))
        else $error("pixel scan left the clipped box");

    // frame store writes stay below the store depth
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr <= ADDR_LAST))
        else $error("frame store write out of range");

endmodule

`default_nettype wire
